>>> src/mrmc_pkg.sv
// Shared constants, types and helpers of the memory region map coalescer.
package mrmc_pkg;

  // Table geometry and address width
  localparam int TABLE_ENTRIES = 64;
  localparam int ADDRESS_BITS  = 52;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Request and response field widths
  localparam int TYPE_W  = 8;
  localparam int START_W = 52;
  localparam int PAGES_W = 40;
  localparam int CLS_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int TOTAL_W = 42;

  // Internal arithmetic widths
  localparam int PAGE_SHIFT = 12;
  localparam int KIB_SHIFT  = 10;
  localparam int SIZE_W     = START_W + 1;
  localparam int END_W      = START_W + 2;
  localparam int KEND_W     = END_W - KIB_SHIFT;
  localparam int EXT_W      = TOTAL_W + 4;

  // Address constants
  localparam logic [START_W-1:0] CONV_LIMIT = START_W'(64'h0a0000);
  localparam logic [START_W-1:0] EXT_FLOOR  = START_W'(64'h10000);
  localparam logic [EXT_W-1:0]   KIB        = EXT_W'(1024);
  localparam logic [START_W-1:0] ADDR_MASK  = (ADDRESS_BITS >= START_W) ? {START_W{1'b1}} :
                                              START_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

  // Region classes
  localparam logic [CLS_W-1:0] CLS_FREE     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_RESERVED = 2'd1;
  localparam logic [CLS_W-1:0] CLS_ACPI     = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NVS      = 2'd3;

  // Firmware type codes that do not map to reserved
  localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE = 8'd1;
  localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 8'd7;
  localparam logic [TYPE_W-1:0] TYPE_ACPI_RECLAIM = 8'd9;
  localparam logic [TYPE_W-1:0] TYPE_ACPI_NVS     = 8'd10;

  // One table entry
  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic hit;
    logic update;
    logic walk;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic walk_done;
    logic last;
  } status_t;

  // Sort a firmware type code into its class
  function automatic logic [CLS_W-1:0] class_of(input logic [TYPE_W-1:0] t);
    logic [CLS_W-1:0] c;
    c = CLS_RESERVED;
    if (t >= TYPE_LOADER_CODE && t <= TYPE_CONVENTIONAL) c = CLS_FREE;
    else if (t == TYPE_ACPI_RECLAIM) c = CLS_ACPI;
    else if (t == TYPE_ACPI_NVS) c = CLS_NVS;
    return c;
  endfunction

endpackage

>>> src/mrmc_if.sv
// Request and response channel interfaces of the coalescer.
interface mrmc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           first_of_map;
  logic                           last_of_map;
  logic [mrmc_pkg::TYPE_W-1:0]    region_type;
  logic [mrmc_pkg::START_W-1:0]   region_start;
  logic [mrmc_pkg::PAGES_W-1:0]   region_pages;

  modport source (output valid, first_of_map, last_of_map, region_type, region_start,
                  region_pages, input ready);
  modport sink (input valid, first_of_map, last_of_map, region_type, region_start,
                region_pages, output ready);
endinterface

interface mrmc_out_if;
  logic                           valid;
  logic                           ready;
  logic [mrmc_pkg::CLS_W-1:0]     entry_class;
  logic [mrmc_pkg::SLOT_W-1:0]    slot_used;
  logic                           was_merged;
  logic                           table_full;
  logic [mrmc_pkg::COUNT_W-1:0]   entry_count;
  logic                           totals_valid;
  logic [mrmc_pkg::TOTAL_W-1:0]   conventional_kib;
  logic [mrmc_pkg::TOTAL_W-1:0]   extended_kib;

  modport source (output valid, entry_class, slot_used, was_merged, table_full, entry_count,
                  totals_valid, conventional_kib, extended_kib, input ready);
  modport sink (input valid, entry_class, slot_used, was_merged, table_full, entry_count,
                totals_valid, conventional_kib, extended_kib, output ready);
endinterface

>>> src/mrmc_ctrl.sv
// Controller state machine: sequences scan, update, totals walk and response.
module mrmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mrmc_pkg::status_t st,
  output mrmc_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_UPDATE;
        end else if (st.scan_done) begin
          state_nxt = ST_UPDATE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = st.last ? ST_WALK : ST_RESP;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Response valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A response is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free) else $error("response loaded over a pending one");
  // Requests are only taken while idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> state_r == ST_IDLE) else $error("request taken while busy");
  // A totals walk always follows an update of a last descriptor
  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && !$past(state_r == ST_WALK) |-> $past(cmd.update && st.last))
    else $error("walk entered without last descriptor");

endmodule

>>> src/mrmc_dp.sv
// Datapath: region table memory, scan compare, merge/append and totals walk.
module mrmc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mrmc_pkg::cmd_t                 cmd,
  output mrmc_pkg::status_t              st,
  input  logic                           first_of_map,
  input  logic                           last_of_map,
  input  logic [mrmc_pkg::TYPE_W-1:0]    region_type,
  input  logic [mrmc_pkg::START_W-1:0]   region_start,
  input  logic [mrmc_pkg::PAGES_W-1:0]   region_pages,
  output logic [mrmc_pkg::CLS_W-1:0]     entry_class,
  output logic [mrmc_pkg::SLOT_W-1:0]    slot_used,
  output logic                           was_merged,
  output logic                           table_full,
  output logic [mrmc_pkg::COUNT_W-1:0]   entry_count,
  output logic                           totals_valid,
  output logic [mrmc_pkg::TOTAL_W-1:0]   conventional_kib,
  output logic [mrmc_pkg::TOTAL_W-1:0]   extended_kib
);

  // Region table
  mrmc_pkg::entry_t mem [mrmc_pkg::TABLE_ENTRIES];
  mrmc_pkg::entry_t rd_data_r;

  // Current request
  logic [mrmc_pkg::CLS_W-1:0]   cls_r;
  logic [mrmc_pkg::START_W-1:0] start_r;
  logic [mrmc_pkg::SIZE_W-1:0]  size_r;
  logic [mrmc_pkg::END_W-1:0]   end_r;
  logic                         last_r;

  // Table control
  logic [mrmc_pkg::CNT_W-1:0]   count_r;
  logic [mrmc_pkg::CNT_W-1:0]   addr_r;
  logic                         pend_r;
  logic [mrmc_pkg::IDX_W-1:0]   pend_idx_r;
  logic                         at_end;
  logic                         room;

  // Hit capture
  logic                         merged_r, full_r;
  logic [mrmc_pkg::IDX_W-1:0]   slot_r;
  logic [mrmc_pkg::START_W-1:0] hit_start_r;
  logic [mrmc_pkg::END_W-1:0]   hit_end_r;
  logic                         case2_r;

  // Totals
  logic [mrmc_pkg::KEND_W-1:0]  conv_r;
  logic [mrmc_pkg::EXT_W-1:0]   ext_r, tgt_r;

  // Response register
  logic [mrmc_pkg::CLS_W-1:0]   entry_class_r;
  logic [mrmc_pkg::SLOT_W-1:0]  slot_used_r;
  logic                         was_merged_r;
  logic                         table_full_r;
  logic [mrmc_pkg::COUNT_W-1:0] entry_count_r;
  logic                         totals_valid_r;
  logic [mrmc_pkg::TOTAL_W-1:0] conventional_kib_r;
  logic [mrmc_pkg::TOTAL_W-1:0] extended_kib_r;

  logic [mrmc_pkg::START_W-1:0] req_start;
  logic [mrmc_pkg::SIZE_W-1:0]  req_size;
  logic [mrmc_pkg::END_W-1:0]   rd_end;
  logic                         cls_eq, case1, case2, match;
  logic [mrmc_pkg::START_W-1:0] new_start;
  logic [mrmc_pkg::END_W-1:0]   new_end;
  logic                         wr_en;
  logic [mrmc_pkg::IDX_W-1:0]   wr_addr;
  mrmc_pkg::entry_t             wr_data;
  logic [mrmc_pkg::KEND_W-1:0]  rd_kend;
  logic [mrmc_pkg::EXT_W-1:0]   rd_ksize;
  logic                         conv_take, ext_take;

  // Request decode
  assign req_start = region_start & mrmc_pkg::ADDR_MASK;
  assign req_size  = mrmc_pkg::SIZE_W'({region_pages, {mrmc_pkg::PAGE_SHIFT{1'b0}}});

  assign at_end = (addr_r == count_r);
  assign room   = (count_r != mrmc_pkg::CNT_W'(mrmc_pkg::TABLE_ENTRIES));

  // Overlap or touch test against the entry just read
  assign rd_end = mrmc_pkg::END_W'(rd_data_r.start) + mrmc_pkg::END_W'(rd_data_r.size);
  assign cls_eq = (rd_data_r.cls == cls_r);
  assign case1  = (rd_data_r.start <= start_r) && (mrmc_pkg::END_W'(start_r) <= rd_end);
  assign case2  = (start_r <= rd_data_r.start) && (mrmc_pkg::END_W'(rd_data_r.start) <= end_r);
  assign match  = pend_r && cls_eq && (case1 || case2);

  assign st.hit       = match;
  assign st.scan_done = at_end && !match;
  assign st.walk_done = at_end;
  assign st.last      = last_r;

  // Merged entry: keep or take start, end is the larger of both ends
  assign new_start = case2_r ? start_r : hit_start_r;
  assign new_end   = (hit_end_r > end_r) ? hit_end_r : end_r;

  // Table write on update
  assign wr_en   = cmd.update && (merged_r || room);
  assign wr_addr = merged_r ? slot_r : count_r[mrmc_pkg::IDX_W-1:0];
  always_comb begin
    wr_data.cls = cls_r;
    if (merged_r) begin
      wr_data.start = new_start;
      wr_data.size  = mrmc_pkg::SIZE_W'(new_end - mrmc_pkg::END_W'(new_start));
    end else begin
      wr_data.start = start_r;
      wr_data.size  = size_r;
    end
  end

  // Table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[addr_r[mrmc_pkg::IDX_W-1:0]];
  end

  // Walk terms for the entry just read
  assign rd_kend   = mrmc_pkg::KEND_W'(rd_end >> mrmc_pkg::KIB_SHIFT);
  assign rd_ksize  = mrmc_pkg::EXT_W'(rd_data_r.size >> mrmc_pkg::KIB_SHIFT);
  assign conv_take = pend_r && (rd_data_r.start < mrmc_pkg::CONV_LIMIT) && (rd_kend > conv_r);
  assign ext_take  = pend_r && (rd_data_r.start >= mrmc_pkg::EXT_FLOOR) &&
                     (mrmc_pkg::EXT_W'(rd_data_r.start >> mrmc_pkg::KIB_SHIFT) == tgt_r);

  // Entry count and read sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      addr_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (first_of_map) count_r <= '0;
        addr_r <= '0;
        pend_r <= 1'b0;
      end else if (cmd.scan || cmd.walk) begin
        pend_r <= !at_end;
        if (!at_end) addr_r <= addr_r + 1'b1;
      end else if (cmd.update) begin
        addr_r <= '0;
        pend_r <= 1'b0;
        if (!merged_r && room) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan || cmd.walk) pend_idx_r <= addr_r[mrmc_pkg::IDX_W-1:0];
  end

  // Request capture, hit capture and update result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cls_r    <= mrmc_pkg::class_of(region_type);
      start_r  <= req_start;
      size_r   <= req_size;
      end_r    <= mrmc_pkg::END_W'(req_start) + mrmc_pkg::END_W'(req_size);
      last_r   <= last_of_map;
      merged_r <= 1'b0;
      full_r   <= 1'b0;
      slot_r   <= '0;
    end else if (cmd.hit) begin
      merged_r    <= 1'b1;
      slot_r      <= pend_idx_r;
      hit_start_r <= rd_data_r.start;
      hit_end_r   <= rd_end;
      case2_r     <= !case1;
    end else if (cmd.update && !merged_r) begin
      if (room) slot_r <= count_r[mrmc_pkg::IDX_W-1:0];
      else full_r <= 1'b1;
    end
  end

  // Totals accumulation during the walk
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      conv_r <= '0;
      ext_r  <= '0;
      tgt_r  <= mrmc_pkg::KIB;
    end else if (cmd.walk) begin
      if (conv_take) conv_r <= rd_kend;
      if (ext_take) begin
        ext_r <= ext_r + rd_ksize;
        tgt_r <= tgt_r + rd_ksize;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_class_r  <= cls_r;
      slot_used_r    <= mrmc_pkg::SLOT_W'(slot_r);
      was_merged_r   <= merged_r;
      table_full_r   <= full_r;
      entry_count_r  <= mrmc_pkg::COUNT_W'(count_r);
      totals_valid_r <= last_r;
      if (!last_r) conventional_kib_r <= '0;
      else if (conv_r > mrmc_pkg::KEND_W'(mrmc_pkg::TOTAL_MAX))
        conventional_kib_r <= mrmc_pkg::TOTAL_MAX;
      else conventional_kib_r <= mrmc_pkg::TOTAL_W'(conv_r);
      if (!last_r) extended_kib_r <= '0;
      else if (ext_r > mrmc_pkg::EXT_W'(mrmc_pkg::TOTAL_MAX))
        extended_kib_r <= mrmc_pkg::TOTAL_MAX;
      else extended_kib_r <= mrmc_pkg::TOTAL_W'(ext_r);
    end
  end

  assign entry_class      = entry_class_r;
  assign slot_used        = slot_used_r;
  assign was_merged       = was_merged_r;
  assign table_full       = table_full_r;
  assign entry_count      = entry_count_r;
  assign totals_valid     = totals_valid_r;
  assign conventional_kib = conventional_kib_r;
  assign extended_kib     = extended_kib_r;

  // Table never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mrmc_pkg::CNT_W'(mrmc_pkg::TABLE_ENTRIES)) else $error("entry count overflow");
  // A merge leaves the entry count alone
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && merged_r |=> count_r == $past(count_r)) else $error("merge changed count");
  // The read pointer never passes the stored entries
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || cmd.walk) |-> addr_r <= count_r) else $error("read pointer past table end");
  // A dropped region is never also reported as merged
  a_full_merge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(full_r && merged_r)) else $error("dropped and merged together");

endmodule

>>> src/memory_region_map_coalescer_unit.sv
// Top level of the memory region map coalescer: controller, datapath and channel wiring.
//
// Takes one firmware memory descriptor per request and returns one response per request.
// The region table lives in a single-port-read memory that is read one entry a cycle, so
// the time from acceptance to response grows with the number of entries stored; a
// descriptor marked last also walks the table for the totals before its response. A new
// request is taken as soon as the previous response is in the output register, even if
// the sink has not taken it yet. The table needs no clearing pass after reset: only
// entries below the stored count are ever read.
module memory_region_map_coalescer_unit (
  input  logic       clk,
  input  logic       rst_n,
  mrmc_in_if.sink    in_chan,
  mrmc_out_if.source out_chan
);

  mrmc_pkg::cmd_t    cmd;
  mrmc_pkg::status_t st;
  logic              in_ready;
  logic              out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  // Sequencer
  mrmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table and arithmetic
  mrmc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .first_of_map     (in_chan.first_of_map),
    .last_of_map      (in_chan.last_of_map),
    .region_type      (in_chan.region_type),
    .region_start     (in_chan.region_start),
    .region_pages     (in_chan.region_pages),
    .entry_class      (out_chan.entry_class),
    .slot_used        (out_chan.slot_used),
    .was_merged       (out_chan.was_merged),
    .table_full       (out_chan.table_full),
    .entry_count      (out_chan.entry_count),
    .totals_valid     (out_chan.totals_valid),
    .conventional_kib (out_chan.conventional_kib),
    .extended_kib     (out_chan.extended_kib)
  );

endmodule
